>>> rtl/apgm_pkg.sv
`timescale 1ns / 1ps

package apgm_pkg;

   // parse phase
   typedef enum logic [2:0] {
      PH_MAGIC  = 3'd0,
      PH_WIDTH  = 3'd1,
      PH_HEIGHT = 3'd2,
      PH_MAXVAL = 3'd3,
      PH_PIXELS = 3'd4,
      PH_IGNORE = 3'd5
   } phase_type;

   // result kinds
   localparam logic [2:0] KIND_WIDTH  = 3'd0;
   localparam logic [2:0] KIND_HEIGHT = 3'd1;
   localparam logic [2:0] KIND_MAXVAL = 3'd2;
   localparam logic [2:0] KIND_PIXEL  = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   // end status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_NO_HEADER = 2'd2;
   localparam logic [1:0] ST_MISMATCH  = 2'd3;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_TWO   = 8'h32;

   localparam logic [3:0]  RADIX     = 4'd10;
   localparam logic [15:0] VALUE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic [1:0]  status;
      logic        end_of_run;
   } rsp_type;

   // up to two results from one input item, first in order first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

>>> rtl/apgm_parser.sv
`timescale 1ns / 1ps

module apgm_parser
   import apgm_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  req,
   output push_type push
);

   localparam logic [15:0] DIM_MAX16 = 16'((32'd1 << DIM_BITS) - 32'd1);

   phase_type              phase_ff, phase_in;
   logic                   in_comment_ff, in_comment_in;
   logic                   in_token_ff, in_token_in;
   logic                   dig_end_ff, dig_end_in;
   logic [15:0]            tv_ff, tv_in;
   logic [1:0]             mpos_ff, mpos_in;
   logic                   mbad_ff, mbad_in;
   logic [DIM_BITS-1:0]    width_ff, width_in;
   logic [DIM_BITS-1:0]    height_ff, height_in;
   logic [7:0]             maxv_ff, maxv_in;
   logic [31:0]            count_ff, count_in;
   logic [2*DIM_BITS-1:0]  area_ff;

   logic [7:0]          b;
   logic                active, is_sep, is_digit, sep, tc, tok_after, fin;
   logic [19:0]         prod;
   logic [15:0]         tv_tc, tv_cur;
   logic                de_cur;
   logic [1:0]          mpos_cur;
   logic                mbad_cur;
   logic [DIM_BITS-1:0] tv_dim;
   logic                px_room, emit_tok;
   phase_type           ph_fin;
   logic [31:0]         count_fin;
   logic [1:0]          end_st;
   rsp_type             tok_res, end_res;

   // byte classes
   assign b        = req.byte_in;
   assign active   = (phase_ff != PH_IGNORE);
   assign is_sep   = (b == CH_HASH) ||
                     (b inside {CH_SPACE, CH_FF, CH_LF, CH_CR, CH_TAB, CH_VT});
   assign is_digit = (b inside {[CH_ZERO:CH_NINE]});
   assign sep      = active && !in_comment_ff && is_sep;
   assign tc       = active && !in_comment_ff && !is_sep;

   // token value accumulation, saturating
   assign prod  = 20'(tv_ff) * 20'(RADIX) + 20'(b - CH_ZERO);
   assign tv_tc = (!dig_end_ff && is_digit) ?
                  ((prod[19:16] != 4'd0) ? VALUE_MAX : prod[15:0]) : tv_ff;

   // token registers after this byte's character, if any
   always_comb begin
      tv_cur   = tv_ff;
      de_cur   = dig_end_ff;
      mpos_cur = mpos_ff;
      mbad_cur = mbad_ff;
      if (tc) begin
         tv_cur = tv_tc;
         de_cur = dig_end_ff || !is_digit;
         if (phase_ff == PH_MAGIC) begin
            case (mpos_ff)
               2'd0: begin
                  mbad_cur = mbad_ff || (b != CH_P);
                  mpos_cur = 2'd1;
               end
               2'd1: begin
                  mbad_cur = mbad_ff || (b != CH_TWO);
                  mpos_cur = 2'd2;
               end
               default: mbad_cur = 1'b1;
            endcase
         end
      end
   end

   // at most one token closes per byte: at a separator or at the last byte
   assign tok_after = tc || (in_token_ff && !sep);
   assign fin       = (sep && in_token_ff) || (req.last && active && tok_after);

   assign tv_dim   = (tv_cur > DIM_MAX16) ? '1 : tv_cur[DIM_BITS-1:0];
   assign px_room  = (count_ff < 32'(area_ff));
   assign emit_tok = fin && ((phase_ff == PH_WIDTH) || (phase_ff == PH_HEIGHT) ||
                             (phase_ff == PH_MAXVAL) ||
                             ((phase_ff == PH_PIXELS) && px_room));

   // phase and pixel count once the token has closed
   always_comb begin
      ph_fin    = phase_ff;
      count_fin = count_ff;
      if (fin) begin
         case (phase_ff)
            PH_MAGIC:  ph_fin = (mbad_cur || mpos_cur != 2'd2) ? PH_IGNORE : PH_WIDTH;
            PH_WIDTH:  ph_fin = PH_HEIGHT;
            PH_HEIGHT: ph_fin = PH_MAXVAL;
            PH_MAXVAL: ph_fin = PH_PIXELS;
            PH_PIXELS: begin
               if (count_ff != 32'hFFFF_FFFF) count_fin = count_ff + 32'd1;
            end
            default: ph_fin = phase_ff;
         endcase
      end
   end

   // end status; the product register is updated the cycle after the dimensions, so a file
   // closing on its maxval token checks the dimensions directly
   always_comb begin
      if (ph_fin == PH_IGNORE || ph_fin == PH_MAGIC) begin
         end_st = ST_BAD_MAGIC;
      end else if (ph_fin != PH_PIXELS) begin
         end_st = ST_NO_HEADER;
      end else if (phase_ff == PH_MAXVAL) begin
         end_st = (width_ff != '0 && height_ff != '0) ? ST_MISMATCH : ST_OK;
      end else begin
         end_st = (count_fin != 32'(area_ff)) ? ST_MISMATCH : ST_OK;
      end
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      in_comment_in = in_comment_ff;
      in_token_in   = in_token_ff;
      dig_end_in    = dig_end_ff;
      tv_in         = tv_ff;
      mpos_in       = mpos_ff;
      mbad_in       = mbad_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      maxv_in       = maxv_ff;
      count_in      = count_ff;
      if (take) begin
         if (req.last) begin
            phase_in      = PH_MAGIC;
            in_comment_in = 1'b0;
            in_token_in   = 1'b0;
            dig_end_in    = 1'b0;
            tv_in         = '0;
            mpos_in       = '0;
            mbad_in       = 1'b0;
            width_in      = '0;
            height_in     = '0;
            maxv_in       = '0;
            count_in      = '0;
         end else begin
            phase_in = ph_fin;
            count_in = count_fin;
            if (active) begin
               in_comment_in = in_comment_ff ? (b != CH_LF) : (b == CH_HASH);
            end
            if (fin) begin
               in_token_in = 1'b0;
               dig_end_in  = 1'b0;
               tv_in       = '0;
               mpos_in     = '0;
               mbad_in     = 1'b0;
            end else begin
               in_token_in = tok_after;
               dig_end_in  = de_cur;
               tv_in       = tv_cur;
               mpos_in     = mpos_cur;
               mbad_in     = mbad_cur;
            end
            if (fin && phase_ff == PH_WIDTH)  width_in  = tv_dim;
            if (fin && phase_ff == PH_HEIGHT) height_in = tv_dim;
            if (fin && phase_ff == PH_MAXVAL) maxv_in   = tv_cur[7:0];
         end
      end
   end

   // results
   always_comb begin
      tok_res = '0;
      case (phase_ff)
         PH_WIDTH: begin
            tok_res.kind  = KIND_WIDTH;
            tok_res.value = 16'(tv_dim);
         end
         PH_HEIGHT: begin
            tok_res.kind  = KIND_HEIGHT;
            tok_res.value = 16'(tv_dim);
         end
         PH_MAXVAL: begin
            tok_res.kind  = KIND_MAXVAL;
            tok_res.value = {8'd0, tv_cur[7:0]};
         end
         default: begin
            tok_res.kind  = KIND_PIXEL;
            tok_res.value = {8'd0, maxv_ff - tv_cur[7:0]};
         end
      endcase

      end_res            = '0;
      end_res.kind       = KIND_END;
      end_res.status     = end_st;
      end_res.end_of_run = 1'b1;

      push = '0;
      if (take) begin
         push.count  = 2'(emit_tok) + 2'(req.last);
         push.first  = emit_tok ? tok_res : end_res;
         push.second = end_res;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         in_comment_ff <= 1'b0;
         in_token_ff   <= 1'b0;
         dig_end_ff    <= 1'b0;
         tv_ff         <= '0;
         mpos_ff       <= '0;
         mbad_ff       <= 1'b0;
         width_ff      <= '0;
         height_ff     <= '0;
         maxv_ff       <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         in_comment_ff <= in_comment_in;
         in_token_ff   <= in_token_in;
         dig_end_ff    <= dig_end_in;
         tv_ff         <= tv_in;
         mpos_ff       <= mpos_in;
         mbad_ff       <= mbad_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         maxv_ff       <= maxv_in;
         count_ff      <= count_in;
      end
   end

   // pixel total, registered from the dimension registers
   always_ff @(posedge clock) begin
      area_ff <= width_ff * height_ff;
   end

endmodule

>>> rtl/apgm_rsp_fifo.sv
`timescale 1ns / 1ps

module apgm_rsp_fifo
   import apgm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   rsp_type         mem [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            pop;
   logic [AW-1:0]   wr_next;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for two items must remain before another input is taken
   assign full      = (cnt_ff > (AW+1)'(DEPTH - 2));
   assign wr_next   = wr_ff + AW'(1);

   // pointers and fill level
   always_comb begin
      wr_in  = wr_ff + AW'(push.count);
      rd_in  = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push.count) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ff]   <= push.first;
      if (push.count == 2'd2) mem[wr_next] <= push.second;
   end

endmodule

>>> rtl/ascii_pgm_parse_invert.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports                            Item
// req      in   req_valid req_stall req_data     one text byte, last flag
// rsp      out  rsp_valid rsp_stall rsp_data     header, inverted pixel, end
//
// One byte is taken every cycle while req_stall is low; its results go into
// a four-item result queue fed by combinational parse logic.
// The last byte of a file may give two results; the queue drains one a cycle while rsp_stall is low.
// req_stall rises while fewer than two queue slots are free.
// Synchronous reset returns the parser to expecting the magic token and
// empties the queue; the last byte of a file does the same for the parser.

module ascii_pgm_parse_invert
   import apgm_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     take;
   push_type push;

   assign take = req_valid && !req_stall;

   apgm_parser #(
      .DIM_BITS(DIM_BITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (push)
   );

   apgm_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
